>>> rtl/pfa_pkg.sv
// Shared constants, codes and types of the partition fit allocator.
package pfa_pkg;

  localparam int Partitions = 16;
  localparam int SizeBits   = 16;
  localparam int IdxBits    = (Partitions > 1) ? $clog2(Partitions) : 1;
  localparam int CntBits    = $clog2(Partitions + 1);

  localparam int SizeW      = 16;
  localparam int IdxW       = 4;
  localparam int FreeW      = 16;
  localparam int StatusW    = 2;
  localparam int ModeW      = 2;
  localparam int OutDataW   = 24;

  typedef enum logic [ModeW-1:0] {
    MODE_FIRST = 2'd0,
    MODE_BEST  = 2'd1,
    MODE_WORST = 2'd2,
    MODE_SPARE = 2'd3
  } fit_mode_e;

  typedef enum logic [StatusW-1:0] {
    ST_ADDED  = 2'd0,
    ST_PLACED = 2'd1,
    ST_WAIT   = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef enum logic {
    OP_ADD     = 1'b0,
    OP_REQUEST = 1'b1
  } op_e;

  typedef struct packed {
    fit_mode_e mode;
    logic      found;
  } sel_ctl_t;

endpackage

>>> rtl/pfa_mem.sv
// Partition free-size table: one write port, one registered read port.
module pfa_mem (
  input  logic                          clk_i,
  input  logic                          wr_en_i,
  input  logic [pfa_pkg::IdxBits-1:0]   wr_addr_i,
  input  logic [pfa_pkg::SizeBits-1:0]  wr_data_i,
  input  logic [pfa_pkg::IdxBits-1:0]   rd_addr_i,
  output logic [pfa_pkg::SizeBits-1:0]  rd_data_o
);

  logic [pfa_pkg::SizeBits-1:0] mem_q [pfa_pkg::Partitions];
  logic [pfa_pkg::SizeBits-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/pfa_sel.sv
// Shared compare unit: decides whether the scanned entry replaces the current pick.
module pfa_sel (
  input  pfa_pkg::sel_ctl_t             ctl_i,
  input  logic [pfa_pkg::SizeBits-1:0]  cand_free_i,
  input  logic [pfa_pkg::SizeBits-1:0]  pick_free_i,
  input  logic [pfa_pkg::SizeBits-1:0]  req_size_i,
  output logic                          take_o,
  output logic                          stop_o
);

  logic fits;
  logic better;
  logic first_mode;

  always_comb begin
    fits       = (cand_free_i >= req_size_i);
    first_mode = (ctl_i.mode != pfa_pkg::MODE_BEST) && (ctl_i.mode != pfa_pkg::MODE_WORST);
    case (ctl_i.mode)
      pfa_pkg::MODE_BEST:  better = (cand_free_i < pick_free_i);
      pfa_pkg::MODE_WORST: better = (cand_free_i > pick_free_i);
      default:             better = 1'b0;
    endcase
    take_o = fits && (!ctl_i.found || better);
    stop_o = first_mode && take_o;
  end

endmodule

>>> rtl/partition_fit_allocator_unit.sv
// Partition fit allocator: sequencer, table, compare unit and result register.
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tuser op, tdata size
//  m_axis    out  m_axis_tvalid/m_axis_tready   tuser status, tdata index|free_after
//  cfg       in   cfg_valid_i/cfg_ready_o       cfg_data_i fit_mode
//
//  An add beat, and a request on an empty table, is answered straight from idle.
//  A request scans the table: the single read port and comparator visit one
//  table entry a cycle, then the pick is written back and the result registered.
//  First fit stops at the first entry that fits.
//  Reset clears the count, the fit mode and the sequencer; the table is not cleared.
//  A new beat is taken only while idle and with the result register free or draining.
module partition_fit_allocator_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [pfa_pkg::SizeW-1:0]     s_axis_tdata,  // [15:0] size
  input  logic                          s_axis_tuser,  // [0] op
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [pfa_pkg::OutDataW-1:0]  m_axis_tdata,  // [3:0] partition_index, [19:4] free_after
  output logic [pfa_pkg::StatusW-1:0]   m_axis_tuser,  // [1:0] status
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pfa_pkg::ModeW-1:0]     cfg_data_i
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_e;

  state_e                        state_q, state_d;
  pfa_pkg::fit_mode_e            mode_q;
  logic [pfa_pkg::CntBits-1:0]   cnt_q, cnt_d;
  logic [pfa_pkg::IdxBits-1:0]   ptr_q, ptr_d;
  logic [pfa_pkg::IdxBits-1:0]   pick_idx_q, pick_idx_d;
  logic [pfa_pkg::SizeBits-1:0]  pick_free_q, pick_free_d;
  logic [pfa_pkg::SizeBits-1:0]  size_q, size_d;
  logic                          found_q, found_d;

  logic                          out_valid_q, out_valid_d;
  pfa_pkg::status_e              out_status_q, out_status_d;
  logic [pfa_pkg::IdxW-1:0]      out_idx_q, out_idx_d;
  logic [pfa_pkg::FreeW-1:0]     out_free_q, out_free_d;

  logic                          wr_en;
  logic [pfa_pkg::IdxBits-1:0]   wr_addr;
  logic [pfa_pkg::SizeBits-1:0]  wr_data;
  logic [pfa_pkg::IdxBits-1:0]   rd_addr;
  logic [pfa_pkg::SizeBits-1:0]  rd_data;

  pfa_pkg::sel_ctl_t             sel_ctl;
  logic                          take;
  logic                          stop;
  logic                          out_room;
  logic                          in_beat;
  logic                          last_entry;
  logic [pfa_pkg::SizeBits-1:0]  in_size;
  logic [pfa_pkg::SizeBits-1:0]  new_free;

  assign out_room      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && out_room;
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign in_size       = pfa_pkg::SizeBits'(s_axis_tdata);
  assign cfg_ready_o   = 1'b1;
  assign last_entry    = ((pfa_pkg::CntBits'(ptr_q) + 1'b1) == cnt_q);
  assign new_free      = pick_free_q - size_q;
  assign sel_ctl       = '{mode: mode_q, found: found_q};

  pfa_mem u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  pfa_sel u_sel (
    .ctl_i       (sel_ctl),
    .cand_free_i (rd_data),
    .pick_free_i (pick_free_q),
    .req_size_i  (size_q),
    .take_o      (take),
    .stop_o      (stop)
  );

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    ptr_d        = ptr_q;
    pick_idx_d   = pick_idx_q;
    pick_free_d  = pick_free_q;
    size_d       = size_q;
    found_d      = found_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_status_d = out_status_q;
    out_idx_d    = out_idx_q;
    out_free_d   = out_free_q;
    wr_en        = 1'b0;
    wr_addr      = pick_idx_q;
    wr_data      = new_free;
    rd_addr      = '0;

    case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          if (s_axis_tuser == pfa_pkg::OP_ADD) begin
            out_valid_d = 1'b1;
            if (cnt_q >= pfa_pkg::CntBits'(pfa_pkg::Partitions)) begin
              out_status_d = pfa_pkg::ST_FULL;
              out_idx_d    = '0;
              out_free_d   = '0;
            end else begin
              wr_en        = 1'b1;
              wr_addr      = pfa_pkg::IdxBits'(cnt_q);
              wr_data      = in_size;
              cnt_d        = cnt_q + 1'b1;
              out_status_d = pfa_pkg::ST_ADDED;
              out_idx_d    = pfa_pkg::IdxW'(cnt_q);
              out_free_d   = pfa_pkg::FreeW'(in_size);
            end
          end else if (cnt_q == '0) begin
            out_valid_d  = 1'b1;
            out_status_d = pfa_pkg::ST_WAIT;
            out_idx_d    = '0;
            out_free_d   = '0;
          end else begin
            size_d  = in_size;
            ptr_d   = '0;
            found_d = 1'b0;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        rd_addr = ptr_q + 1'b1;
        ptr_d   = ptr_q + 1'b1;
        if (take) begin
          found_d     = 1'b1;
          pick_idx_d  = ptr_q;
          pick_free_d = rd_data;
        end
        if (last_entry || stop) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_room) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
          if (found_q) begin
            wr_en        = 1'b1;
            out_status_d = pfa_pkg::ST_PLACED;
            out_idx_d    = pfa_pkg::IdxW'(pick_idx_q);
            out_free_d   = pfa_pkg::FreeW'(new_free);
          end else begin
            out_status_d = pfa_pkg::ST_WAIT;
            out_idx_d    = '0;
            out_free_d   = '0;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= pfa_pkg::MODE_FIRST;
      cnt_q       <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        mode_q <= pfa_pkg::fit_mode_e'(cfg_data_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q        <= ptr_d;
    pick_idx_q   <= pick_idx_d;
    pick_free_q  <= pick_free_d;
    size_q       <= size_d;
    out_status_q <= out_status_d;
    out_idx_q    <= out_idx_d;
    out_free_q   <= out_free_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {{(pfa_pkg::OutDataW - pfa_pkg::FreeW - pfa_pkg::IdxW){1'b0}},
                          out_free_q, out_idx_q};

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= pfa_pkg::CntBits'(pfa_pkg::Partitions))
    else $error("partition count beyond table depth");

  a_add_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && s_axis_tuser == pfa_pkg::OP_ADD
     && cnt_q < pfa_pkg::CntBits'(pfa_pkg::Partitions))
    |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("accepted add did not grow the table");

  a_pick_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && found_q) |-> pfa_pkg::CntBits'(pick_idx_q) < cnt_q)
    else $error("picked partition outside the filled table");

  a_wait_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == pfa_pkg::ST_WAIT) |-> (out_idx_q == '0 && out_free_q == '0))
    else $error("wait result carries a partition");
`endif

endmodule
